// File: rtl/meu_pkg.sv
// ----------------------------------------------------------------------------
// meu_pkg: shared constants for the modular exponentiation unit
// Default operand width and sequencer state codes.
// ----------------------------------------------------------------------------
`default_nettype none

package meu_pkg;

    localparam int unsigned DEFAULT_OPERAND_WIDTH = 32;

    localparam int unsigned STATE_W = 2;

    localparam logic [STATE_W-1:0] ST_IDLE   = 2'd0;
    localparam logic [STATE_W-1:0] ST_REDUCE = 2'd1;
    localparam logic [STATE_W-1:0] ST_MUL    = 2'd2;
    localparam logic [STATE_W-1:0] ST_DONE   = 2'd3;

endpackage

`default_nettype wire

// File: rtl/modular_exponentiation_unit.sv
// ----------------------------------------------------------------------------
// modular_exponentiation_unit: base to the exponent modulo a held modulus
// Right-to-left square-and-multiply; bit-serial modular multipliers.
// ----------------------------------------------------------------------------
// Input channel i_in_valid/o_in_ready carries base and exponent; output
// channel o_out_valid/i_out_ready carries the result. i_cfg_we writes the
// modulus at once; write it only while the unit is idle.
// One transaction is worked on at a time. The base is first reduced by a
// restoring remainder unit, one bit per cycle. For each exponent bit the
// multiply and the square then run side by side, one multiplier bit per
// cycle, both fed from the same base shift register. Work stops once the
// remaining exponent bits are all zero; a zero exponent skips the work and
// gives a result of 1. The unit returns to idle only when the result is
// stored, and takes the next transaction from there. A new transaction is
// taken while a finished result still waits in the output register; if
// the receiver stalls, the next result holds in the final state until the
// output register frees. Reset clears the control state, drops any
// transaction in flight and sets the modulus to 1.
// ----------------------------------------------------------------------------
`default_nettype none

module modular_exponentiation_unit #(
    parameter int unsigned OPERAND_WIDTH = meu_pkg::DEFAULT_OPERAND_WIDTH
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [OPERAND_WIDTH-1:0] i_cfg_wdata,
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire logic [OPERAND_WIDTH-1:0] i_base_value,
    input  wire logic [OPERAND_WIDTH-1:0] i_exponent,
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output logic [OPERAND_WIDTH-1:0]      o_power_result
);

    import meu_pkg::*;

    localparam int unsigned W  = OPERAND_WIDTH;
    localparam int unsigned CW = $clog2(W);
    localparam logic [CW-1:0] LAST_BIT = CW'(W - 1);

    typedef logic [W-1:0] t_word;

    // acc*2 + bit*a modulo m, with acc and a below m
    function automatic t_word f_mac(input t_word acc, input t_word a,
                                    input logic bt, input logic [W:0] m);
        logic [W+1:0] s;
        logic [W+1:0] m1;
        logic [W+1:0] m2;
        s  = {1'b0, acc, 1'b0} + (bt ? {2'b00, a} : '0);
        m1 = {1'b0, m};
        m2 = {m, 1'b0};
        if (s >= m2) begin
            return t_word'(s - m2);
        end else if (s >= m1) begin
            return t_word'(s - m1);
        end
        return t_word'(s);
    endfunction

    // remainder step: rem*2 + bit, one conditional subtract
    function automatic t_word f_rem(input t_word rem, input logic bt,
                                    input logic [W:0] m);
        logic [W:0] s;
        s = {rem, bt};
        if (s >= m) begin
            return t_word'(s - m);
        end
        return t_word'(s);
    endfunction

    logic [STATE_W-1:0] r_state, n_state;
    t_word              r_mod;
    t_word              r_base, n_base;
    t_word              r_res, n_res;
    t_word              r_exp, n_exp;
    t_word              r_bsh, n_bsh;
    t_word              r_acc1, n_acc1;
    t_word              r_acc2, n_acc2;
    logic [CW-1:0]      r_cnt, n_cnt;
    t_word              r_out;
    logic               r_ovalid;

    logic [W:0] mod_ext;
    logic       bt;
    logic       out_free;
    t_word      exp_next;

    assign mod_ext  = {(r_mod == '0), r_mod};
    assign bt       = r_bsh[W-1];
    assign out_free = !r_ovalid || i_out_ready;
    assign exp_next = r_exp >> 1;

    assign o_in_ready     = (r_state == ST_IDLE);
    assign o_out_valid    = r_ovalid;
    assign o_power_result = r_out;

    always_comb begin
        n_state = r_state;
        n_base  = r_base;
        n_res   = r_res;
        n_exp   = r_exp;
        n_bsh   = r_bsh;
        n_acc1  = r_acc1;
        n_acc2  = r_acc2;
        n_cnt   = r_cnt;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_exp  = i_exponent;
                    n_bsh  = i_base_value;
                    n_acc2 = '0;
                    n_cnt  = '0;
                    if (i_exponent == '0) begin
                        n_res   = t_word'(1);
                        n_state = ST_DONE;
                    end else begin
                        n_res   = (r_mod == t_word'(1)) ? '0 : t_word'(1);
                        n_state = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE: begin
                n_acc2 = f_rem(r_acc2, bt, mod_ext);
                n_bsh  = r_bsh << 1;
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == LAST_BIT) begin
                    n_base  = n_acc2;
                    n_bsh   = n_acc2;
                    n_acc1  = '0;
                    n_acc2  = '0;
                    n_cnt   = '0;
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_acc1 = f_mac(r_acc1, r_res, bt, mod_ext);
                n_acc2 = f_mac(r_acc2, r_base, bt, mod_ext);
                n_bsh  = r_bsh << 1;
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == LAST_BIT) begin
                    if (r_exp[0]) begin
                        n_res = n_acc1;
                    end
                    n_base = n_acc2;
                    n_bsh  = n_acc2;
                    n_exp  = exp_next;
                    n_acc1 = '0;
                    n_acc2 = '0;
                    n_cnt  = '0;
                    if (exp_next == '0) begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_mod    <= t_word'(1);
            r_ovalid <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (i_cfg_we) begin
                r_mod <= i_cfg_wdata;
            end
            if (r_state == ST_DONE && out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_base <= n_base;
        r_res  <= n_res;
        r_exp  <= n_exp;
        r_bsh  <= n_bsh;
        r_acc1 <= n_acc1;
        r_acc2 <= n_acc2;
        if (r_state == ST_DONE && out_free) begin
            r_out <= r_res;
        end
    end

endmodule

`default_nettype wire
